// ----- rtl/assert_macros.svh -----
// concurrent assertion helpers, sampled on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/y2r_pkg.sv -----
package y2r_pkg;

  typedef enum logic [1:0] {
    FMT_RGB  = 2'd0,
    FMT_BGR  = 2'd1,
    FMT_YUYV = 2'd2,
    FMT_UYVY = 2'd3
  } pix_fmt_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
  } out_word_t;

  // bt.601 coefficients, scaled by 256
  localparam int unsigned CoefRv = 359;
  localparam int unsigned CoefGu = 88;
  localparam int unsigned CoefGv = 183;
  localparam int unsigned CoefBu = 454;
  localparam int unsigned ChromaOfs = 128;

  // saturate an 11-bit signed channel to 0..255
  function automatic logic [7:0] clamp_byte(input logic signed [10:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/y2r_pixel.sv -----
module y2r_pixel (
  input  logic              [7:0] luma,
  input  logic signed       [8:0] cb,
  input  logic signed       [8:0] cr,
  output logic              [7:0] red,
  output logic              [7:0] green,
  output logic              [7:0] blue
);
  import y2r_pkg::*;

  logic signed [17:0] prod_rv;
  logic signed [17:0] prod_g;
  logic signed [17:0] prod_bu;
  logic signed [10:0] luma_s;
  logic signed [10:0] ofs_r;
  logic signed [10:0] ofs_g;
  logic signed [10:0] ofs_b;

  assign prod_rv = 18'(signed'(18'(CoefRv))) * 18'(cr);
  assign prod_g  = 18'(signed'(18'(CoefGu))) * 18'(cb)
                 + 18'(signed'(18'(CoefGv))) * 18'(cr);
  assign prod_bu = 18'(signed'(18'(CoefBu))) * 18'(cb);

  // floor shift by 8: drop the low byte, keep the sign
  assign ofs_r  = 11'(signed'(prod_rv[17:8]));
  assign ofs_g  = 11'(signed'(prod_g[17:8]));
  assign ofs_b  = 11'(signed'(prod_bu[17:8]));
  assign luma_s = signed'({3'b000, luma});

  assign red   = clamp_byte(luma_s + ofs_r);
  assign green = clamp_byte(luma_s - ofs_g);
  assign blue  = clamp_byte(luma_s + ofs_b);

endmodule

// ----- rtl/yuv422_to_rgb_converter.sv -----
// channel   ports                           word
// --------  ------------------------------  ---------------------------------
// input     in_valid / in_ready / in_data   six raw bytes of one pixel pair
// output    out_valid / out_ready / out_data two rgb pixels
// config    cfg_wr_en / cfg_wr_data         pixel_format, 2 bits
//
// one word per cycle sustained while out_ready stays high; input register then
// result register with the conversion between them
// rst_n (synchronous) clears both valid flags and sets pixel_format to rgb
// a stalled result holds the output register; the input register keeps
// taking a word as long as the output register can move on
`include "assert_macros.svh"

module yuv422_to_rgb_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  y2r_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output y2r_pkg::out_word_t out_data,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data
);
  import y2r_pkg::*;

  // config register
  pix_fmt_t fmt_r;

  // stage 1: captured input word
  logic     s1_valid_r;
  in_word_t s1_data_r;

  // stage 2: result word
  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t out_data_nxt;

  logic out_adv;
  logic s1_adv;

  // chroma / luma picked out of the byte stream
  logic              [7:0] y0;
  logic              [7:0] y1;
  logic signed       [8:0] cb;
  logic signed       [8:0] cr;
  logic              [7:0] r0, g0, b0, r1, g1, b1;

  // output register frees up when empty or taken this cycle
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGB;
    end else if (cfg_wr_en) begin
      fmt_r <= pix_fmt_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // yuyv: y0 u y1 v, uyvy: u y0 v y1; chroma offset removed here
  always_comb begin
    if (fmt_r == FMT_UYVY) begin
      y0 = s1_data_r.byte1;
      y1 = s1_data_r.byte3;
      cb = signed'({1'b0, s1_data_r.byte0}) - 9'(ChromaOfs);
      cr = signed'({1'b0, s1_data_r.byte2}) - 9'(ChromaOfs);
    end else begin
      y0 = s1_data_r.byte0;
      y1 = s1_data_r.byte2;
      cb = signed'({1'b0, s1_data_r.byte1}) - 9'(ChromaOfs);
      cr = signed'({1'b0, s1_data_r.byte3}) - 9'(ChromaOfs);
    end
  end

  y2r_pixel u_pix_first (
    .luma  (y0),
    .cb    (cb),
    .cr    (cr),
    .red   (r0),
    .green (g0),
    .blue  (b0)
  );

  y2r_pixel u_pix_second (
    .luma  (y1),
    .cb    (cb),
    .cr    (cr),
    .red   (r1),
    .green (g1),
    .blue  (b1)
  );

  // format select: pass-through, outer-byte swap, or converted yuv
  always_comb begin
    unique case (fmt_r)
      FMT_RGB: begin
        out_data_nxt = '{s1_data_r.byte0, s1_data_r.byte1, s1_data_r.byte2,
                         s1_data_r.byte3, s1_data_r.byte4, s1_data_r.byte5};
      end
      FMT_BGR: begin
        out_data_nxt = '{s1_data_r.byte2, s1_data_r.byte1, s1_data_r.byte0,
                         s1_data_r.byte5, s1_data_r.byte4, s1_data_r.byte3};
      end
      FMT_YUYV, FMT_UYVY: begin
        out_data_nxt = '{r0, g0, b0, r1, g1, b1};
      end
      default: begin
        out_data_nxt = '{r0, g0, b0, r1, g1, b1};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // both stages empty right after reset
  `ASSERT_ANY(a_reset_empty, !rst_n |=> (!out_valid_r && !s1_valid_r), "not empty after reset")
  // a captured word must not vanish while the result is stalled
  `ASSERT_CLK(a_s1_hold, (s1_valid_r && out_valid_r && !out_ready) |=> s1_valid_r, "s1 dropped")
  // an accepted word lands in stage 1
  `ASSERT_CLK(a_s1_load, (in_valid && in_ready) |=> s1_valid_r, "accepted word not captured")
  // a new result only comes from a filled stage 1
  `ASSERT_CLK(a_out_src, $rose(out_valid_r) |-> $past(s1_valid_r), "result without source word")

endmodule

// ----- sim/yuv422_to_rgb_converter_test.sv -----
`timescale 1ns / 100ps

module yuv422_to_rgb_converter_test;
  import y2r_pkg::*;

  // bt.601 coefficients over 256, kept signed so the shifts stay arithmetic
  localparam int KRv = 359;
  localparam int KGu = 88;
  localparam int KGv = 183;
  localparam int KBu = 454;
  localparam int UvBias = 128;
  localparam int DrainCycles = 4;
  localparam int StallLimit = 2000;
  localparam int RandPhases = 8;
  localparam int WordsPerPhase = 75;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;

  // pixel pairs waiting to be sent, and the rgb words still owed by the block
  in_word_t pair_queue[$];
  out_word_t rgb_due[$];

  // format the block holds right now, as tracked by the testbench
  pix_fmt_t fmt_now = FMT_RGB;
  bit idle_on = 1'b1;

  int pushed_cnt = 0;
  int accepted_cnt = 0;
  int fail_cnt = 0;
  int stall_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;

  yuv422_to_rgb_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // saturate to one byte
  function automatic logic [7:0] sat8(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  // one pixel from luma and centered chroma, packed r, g, b
  function automatic logic [23:0] yuv_pixel_rgb(input int y, input int u, input int v);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = sat8(y + ((KRv * v) >>> 8));
    g = sat8(y - ((KGu * u + KGv * v) >>> 8));
    b = sat8(y + ((KBu * u) >>> 8));
    return {r, g, b};
  endfunction

  // expected rgb word for one pixel pair under a given source format
  function automatic out_word_t convert_pair(input in_word_t w, input pix_fmt_t fmt);
    out_word_t o;
    int y0;
    int y1;
    int u;
    int v;
    o = '0;
    unique case (fmt)
      FMT_RGB: begin
        o = {w.byte0, w.byte1, w.byte2, w.byte3, w.byte4, w.byte5};
      end
      FMT_BGR: begin
        // outer bytes of each three-byte pixel swap places
        o = {w.byte2, w.byte1, w.byte0, w.byte5, w.byte4, w.byte3};
      end
      default: begin
        if (fmt == FMT_YUYV) begin
          // y0 u y1 v
          y0 = w.byte0;
          u = int'(w.byte1) - UvBias;
          y1 = w.byte2;
          v = int'(w.byte3) - UvBias;
        end else begin
          // u y0 v y1
          u = int'(w.byte0) - UvBias;
          y0 = w.byte1;
          v = int'(w.byte2) - UvBias;
          y1 = w.byte3;
        end
        o = {yuv_pixel_rgb(y0, u, v), yuv_pixel_rgb(y1, u, v)};
      end
    endcase
    return o;
  endfunction

  // random byte with extra weight on the ends and the chroma midpoint
  function automatic logic [7:0] pick_byte();
    unique case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'(UvBias - 4 + $urandom_range(0, 8));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_pair();
    in_word_t w;
    w.byte0 = pick_byte();
    w.byte1 = pick_byte();
    w.byte2 = pick_byte();
    w.byte3 = pick_byte();
    w.byte4 = 8'($urandom);
    w.byte5 = 8'($urandom);
    return w;
  endfunction

  task automatic queue_pair(input in_word_t w);
    pair_queue = {pair_queue, w};
    pushed_cnt++;
  endtask

  // wait until every queued pair went in and every rgb word came out,
  // then let the pipeline settle
  task automatic drain_block();
    while (accepted_cnt != pushed_cnt || rgb_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // format change, only issued with the block idle
  task automatic write_format(input pix_fmt_t f);
    drain_block();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fmt_now = f;
  endtask

  // corner patterns: all zero, all ones, alternating extremes, neutral chroma, one mixed word
  task automatic queue_corners();
    queue_pair({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    queue_pair({8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
    queue_pair({8'h00, 8'hff, 8'h00, 8'hff, 8'haa, 8'h55});
    queue_pair({8'hff, 8'h00, 8'hff, 8'h00, 8'h55, 8'haa});
    queue_pair({8'h80, 8'h80, 8'h80, 8'h80, 8'h01, 8'hfe});
    queue_pair({8'h10, 8'hf0, 8'heb, 8'h10, 8'h12, 8'h34});
  endtask

  // stimulus sequencing
  initial begin
    pix_fmt_t f;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset format first, no write, so the reset value of the register is checked
    queue_corners();
    write_format(FMT_BGR);
    queue_corners();
    write_format(FMT_YUYV);
    queue_corners();
    write_format(FMT_UYVY);
    queue_corners();

    // random phases, the first four walk every format
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: f = FMT_RGB;
        1: f = FMT_UYVY;
        2: f = FMT_BGR;
        3: f = FMT_YUYV;
        default: f = pix_fmt_t'($urandom_range(0, 3));
      endcase
      write_format(f);
      // last phase runs at full rate on both sides
      if (p == RandPhases - 1) idle_on = 1'b0;
      for (int i = 0; i < WordsPerPhase; i++) queue_pair(rand_pair());
    end

    drain_block();
    repeat (2 * DrainCycles) @(posedge clk);
    if (fail_cnt == 0 && rgb_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // driver: holds a word until it is taken, then sends the next or idles a burst
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pair_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        // this cycle is the first of the burst
        in_gap = $urandom_range(1, 7) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= pair_queue.pop_front();
      end
    end
  end

  // result side: random back-pressure bursts
  always @(posedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on every taken pair, check every delivered rgb word
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        rgb_due = {rgb_due, convert_pair(in_data, fmt_now)};
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (rgb_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected rgb word %h", out_data);
        end else begin
          want = rgb_due.pop_front();
          // fields in declaration order, red_first at the top
          for (int k = 0; k < 6; k++) begin
            if (out_data[47 - 8 * k -: 8] !== want[47 - 8 * k -: 8]) begin
              fail_cnt++;
              if (fail_cnt <= 10) begin
                $display("mismatch fmt %s field %0d: expected %h got %h (word exp %h act %h)",
                         fmt_now.name(), k, want[47 - 8 * k -: 8],
                         out_data[47 - 8 * k -: 8], want, out_data);
              end
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
